### rtl/core/hrck_pkg.sv
// hrck_pkg: shared types, constants and the divider step for the hue range color keep block
// no dependencies; imported by hue_range_color_keep
package hrck_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int HUE_W      = 9;   // hue in degrees, 0..359
  localparam int NUM_W      = 14;  // 60 * diff plus rounding term
  localparam int Q_W        = 6;   // quotient never exceeds 60
  localparam int BAND_COUNT = 4;
  localparam int REG_COUNT  = 2 * BAND_COUNT;
  localparam int IDX_W      = 3;
  localparam int PIX_W      = 3 * CH_W;

  // which channel holds the maximum
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  localparam logic [HUE_W-1:0] BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] BASE_BLUE  = 9'd240;
  localparam logic [HUE_W-1:0] BASE_WRAP  = 9'd360;

  // band bounds after reset: low, high for each band
  localparam logic [HUE_W-1:0] BAND_RESET [REG_COUNT] = '{
    9'd320, 9'd359, 9'd170, 9'd175, 9'd200, 9'd220, 9'd45, 9'd60
  };

  // pixel context carried down the pipeline
  typedef struct packed {
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [CH_W-1:0]  mx;
    logic             gray;
    logic [1:0]       sector;
    logic             neg;
    logic [CH_W-1:0]  diff;
    logic [CH_W-1:0]  d;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic [HUE_W-1:0] hue;
  } stage_t;

  // one restoring division step: quotient bit on top, new remainder below
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                              input logic [CH_W-1:0]  d,
                                              input int unsigned      sh);
    logic [NUM_W-1:0] dd;
    logic             ge;
    dd = NUM_W'(d) << sh;
    ge = (rem >= dd);
    return {ge, (ge ? rem - dd : rem)};
  endfunction

endpackage

### rtl/core/hue_range_color_keep.sv
// hue_range_color_keep: pipelined rgb-to-hue, four hue bands, keep or gray out each pixel
// depends on hrck_pkg (types, constants, divider step)
// path: each pixel passes through every stage register, then the output register
// throughput: one pixel per cycle when not stalled; 6-bit hue quotient split over three divider stages
// stalls: each stage holds only while its successor is full and blocked, so bubbles close up
// reset: rst_n low clears all valid bits and restores the band bounds to their defaults
module hue_range_color_keep
  import hrck_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input pixels
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,    // red_in, green_in, blue_in
  // result pixels
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [PIX_W-1:0]       out_tdata,   // red_out, green_out, blue_out
  output logic                   out_tuser,   // hue_matched
  // band register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [HUE_W-1:0]       cfg_data
);

  localparam int NSTG = 6;

  stage_t           s_r   [1:NSTG];
  stage_t           s_nxt [1:NSTG];
  logic [NSTG:1]    v_r;
  logic [NSTG+1:1]  en;
  logic [HUE_W-1:0] band_r [REG_COUNT];

  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_user_r;
  logic [PIX_W-1:0] out_data_nxt;
  logic             out_user_nxt;

  // stage advance: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NSTG+1] = !out_valid_r || out_tready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[1];
  assign cfg_ready = 1'b1;

  // band registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        band_r[i] <= BAND_RESET[i];
      end
    end else if (cfg_valid) begin
      band_r[cfg_index] <= cfg_data;
    end
  end

  // next values of stages 1 to 6
  always_comb begin
    // stage 1: max, min, sector and channel difference
    begin : stg1
      logic [CH_W-1:0] r, g, b, mx, mn;
      r  = in_tdata[CH_W-1:0];
      g  = in_tdata[2*CH_W-1:CH_W];
      b  = in_tdata[3*CH_W-1:2*CH_W];
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s_nxt[1]      = '0;
      s_nxt[1].r    = r;
      s_nxt[1].g    = g;
      s_nxt[1].b    = b;
      s_nxt[1].mx   = mx;
      s_nxt[1].gray = (mx == mn);
      s_nxt[1].d    = mx - mn;
      if (mx == r) begin
        s_nxt[1].sector = SEC_RED;
        s_nxt[1].neg    = (g < b);
        s_nxt[1].diff   = (g >= b) ? g - b : b - g;
      end else if (mx == g) begin
        s_nxt[1].sector = SEC_GREEN;
        s_nxt[1].neg    = (b < r);
        s_nxt[1].diff   = (b >= r) ? b - r : r - b;
      end else begin
        s_nxt[1].sector = SEC_BLUE;
        s_nxt[1].neg    = (r < g);
        s_nxt[1].diff   = (r >= g) ? r - g : g - r;
      end
    end

    // stage 2: dividend 60 * diff, plus d - 1 when rounding up for negative offsets
    begin : stg2
      logic [NUM_W-1:0] dx, rnd;
      dx  = NUM_W'(s_r[1].diff);
      rnd = s_r[1].neg ? NUM_W'(s_r[1].d) - NUM_W'(1) : '0;
      s_nxt[2]     = s_r[1];
      s_nxt[2].rem = (dx << 6) - (dx << 2) + rnd;
      s_nxt[2].q   = '0;
    end

    // stages 3 to 5: two quotient bits each, msb first
    begin : stg345
      logic [NUM_W:0] t3a, t3b, t4a, t4b, t5a, t5b;
      t3a = div_step(s_r[2].rem, s_r[2].d, 5);
      t3b = div_step(t3a[NUM_W-1:0], s_r[2].d, 4);
      s_nxt[3]      = s_r[2];
      s_nxt[3].rem  = t3b[NUM_W-1:0];
      s_nxt[3].q    = {t3a[NUM_W], t3b[NUM_W], 4'b0};

      t4a = div_step(s_r[3].rem, s_r[3].d, 3);
      t4b = div_step(t4a[NUM_W-1:0], s_r[3].d, 2);
      s_nxt[4]      = s_r[3];
      s_nxt[4].rem  = t4b[NUM_W-1:0];
      s_nxt[4].q    = {s_r[3].q[5:4], t4a[NUM_W], t4b[NUM_W], 2'b0};

      t5a = div_step(s_r[4].rem, s_r[4].d, 1);
      t5b = div_step(t5a[NUM_W-1:0], s_r[4].d, 0);
      s_nxt[5]      = s_r[4];
      s_nxt[5].rem  = t5b[NUM_W-1:0];
      s_nxt[5].q    = {s_r[4].q[5:2], t5a[NUM_W], t5b[NUM_W]};
    end

    // stage 6: sector base plus or minus quotient
    begin : stg6
      logic [HUE_W-1:0] qx;
      qx       = HUE_W'(s_r[5].q);
      s_nxt[6] = s_r[5];
      case (s_r[5].sector)
        SEC_RED:   s_nxt[6].hue = s_r[5].neg ? BASE_WRAP - qx : qx;
        SEC_GREEN: s_nxt[6].hue = s_r[5].neg ? BASE_GREEN - qx : BASE_GREEN + qx;
        SEC_BLUE:  s_nxt[6].hue = s_r[5].neg ? BASE_BLUE - qx : BASE_BLUE + qx;
        default:   s_nxt[6].hue = '0;
      endcase
    end
  end

  // output stage: band compare and keep or gray select
  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < BAND_COUNT; k++) begin
      if (s_r[6].hue >= band_r[2*k] && s_r[6].hue <= band_r[2*k+1]) begin
        hit = 1'b1;
      end
    end
    hit          = hit && !s_r[6].gray;
    out_user_nxt = hit;
    out_data_nxt = hit ? {s_r[6].b, s_r[6].g, s_r[6].r}
                       : {s_r[6].mx, s_r[6].mx, s_r[6].mx};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
      if (en[NSTG+1]) out_valid_r <= v_r[NSTG];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG; k++) begin
      if (en[k]) s_r[k] <= s_nxt[k];
    end
    if (en[NSTG+1]) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // quotient of a real hue never exceeds 60
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && !s_r[5].gray |-> s_r[5].q <= Q_W'(60))
    else $error("hue quotient out of range");

  // hue of a colored pixel stays below 360
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] && !s_r[6].gray |-> s_r[6].hue < BASE_WRAP)
    else $error("hue out of range");

  // a gray pixel never matches
  a_gray_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] && s_r[6].gray && en[NSTG+1] |=> !out_tuser)
    else $error("gray pixel flagged as matched");

  // an unmatched result is gray on all three channels
  a_unmatched_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[CH_W-1:0] == out_tdata[2*CH_W-1:CH_W] &&
      out_tdata[CH_W-1:0] == out_tdata[3*CH_W-1:2*CH_W])
    else $error("unmatched result is not gray");

  // an empty output register never blocks the input
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule
